// ----- design/pose_fuzzy_membership_defines.svh -----
`ifndef POSE_FUZZY_MEMBERSHIP_DEFINES_SVH
`define POSE_FUZZY_MEMBERSHIP_DEFINES_SVH

// implication checked at every clock edge outside reset
`define PFM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication with a fixed delay in cycles
`define PFM_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

// ----- design/pfm_pkg.sv -----
package pfm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int unsigned SQ_STAGES = 24;
  localparam int unsigned RAD_W     = 2 * SQ_STAGES;
  localparam int unsigned ROOT_W    = SQ_STAGES;
  localparam int unsigned REM_W     = ROOT_W + 2;

  localparam int unsigned PIPE_LAT = 29;

  // floor((256*(11520-a)+45)/90) + 65536 = floor((8847405 - 256*a)/90)
  localparam logic [23:0] ANG_BIAS   = 24'd8847405;
  localparam logic [24:0] ANG_RECIP  = 25'd23860930;
  localparam int unsigned ANG_SHIFT  = 31;
  localparam logic [16:0] ANG_OFFSET = 17'd65536;

  // floor(x/10) for x below 2^25
  localparam logic [25:0] DIST_RECIP = 26'd53687092;
  localparam int unsigned DIST_SHIFT = 29;
  localparam logic [24:0] DIST_RND   = 25'd4;

  localparam logic [21:0] MEMB_HALF = 22'd16384;
  localparam logic [16:0] MEMB_ONE  = 17'd32768;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [14:0]        adiff;
  } pfm_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pfm_qstat_t;

endpackage

// ----- design/pfm_front.sv -----
module pfm_front
  import pfm_pkg::*;
(
  input  logic               start_i,
  input  logic signed [15:0] robot_x_i,
  input  logic signed [15:0] robot_y_i,
  input  logic signed [14:0] robot_heading_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic signed [14:0] target_heading_i,
  input  pfm_qstat_t         qstat_i,
  output logic               push_o,
  output pfm_entry_t         entry_o
);

  logic signed [15:0] hdiff;
  logic [15:0]        hmag;

  assign hdiff = {robot_heading_i[14], robot_heading_i}
               - {target_heading_i[14], target_heading_i};
  assign hmag  = hdiff[15] ? 16'(-hdiff) : 16'(hdiff);

  assign push_o        = start_i && !qstat_i.full;
  assign entry_o.dx    = {robot_x_i[15], robot_x_i} - {target_x_i[15], target_x_i};
  assign entry_o.dy    = {robot_y_i[15], robot_y_i} - {target_y_i[15], target_y_i};
  assign entry_o.adiff = hmag[14:0];

endmodule

// ----- design/pfm_fifo.sv -----
module pfm_fifo
  import pfm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pfm_entry_t entry_i,
  input  logic       pop_i,
  output pfm_entry_t head_o,
  output pfm_qstat_t qstat_o
);

  pfm_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign qstat_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- design/pfm_sqrt.sv -----
module pfm_sqrt
  import pfm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [RAD_W-1:0]   rad_i,
  input  logic signed [16:0] side_i,
  output logic               valid_o,
  output logic [ROOT_W-1:0]  root_o,
  output logic               rem_nz_o,
  output logic signed [16:0] side_o
);

  logic               vld_q  [SQ_STAGES];
  logic [REM_W-1:0]   rem_q  [SQ_STAGES];
  logic [ROOT_W-1:0]  root_q [SQ_STAGES];
  logic [RAD_W-1:0]   rad_q  [SQ_STAGES-1];
  logic signed [16:0] side_q [SQ_STAGES];

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
    logic               vld_in;
    logic [REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic [RAD_W-1:0]   rad_in;
    logic signed [16:0] side_in;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               take;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_in, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (take) begin
        rem_q[i]  <= REM_W'(rem_sh - trial);
        root_q[i] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[i]  <= REM_W'(rem_sh);
        root_q[i] <= {root_in[ROOT_W-2:0], 1'b0};
      end
      side_q[i] <= side_in;
    end

    if (i < SQ_STAGES - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        rad_q[i] <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign valid_o  = vld_q[SQ_STAGES-1];
  assign root_o   = root_q[SQ_STAGES-1];
  assign rem_nz_o = |rem_q[SQ_STAGES-1];
  assign side_o   = side_q[SQ_STAGES-1];

endmodule

// ----- design/pfm_back.sv -----
module pfm_back
  import pfm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfm_entry_t         head_i,
  input  pfm_qstat_t         qstat_i,
  output logic               pop_o,
  output logic               valid_o,
  output logic [14:0]        dist_small_o,
  output logic [15:0]        dist_large_o,
  output logic signed [16:0] angle_small_o,
  output logic [16:0]        angle_large_o
);

  // squares and angle reciprocal product
  logic               s1_vld_q;
  logic [31:0]        s1_sqx_q, s1_sqy_q;
  logic [16:0]        s1_aq_q;
  logic signed [33:0] sqx, sqy;
  logic [23:0]        ang_num;
  logic [48:0]        ang_prod;

  // radicand
  logic               s2_vld_q;
  logic [RAD_W-1:0]   s2_rad_q;
  logic signed [16:0] s2_asm_q;
  logic [32:0]        sum_sq;

  // root
  logic               sq_vld;
  logic [ROOT_W-1:0]  sq_root;
  logic               sq_rem_nz;
  logic signed [16:0] sq_asm;

  // divide by ten
  logic               s3_vld_q;
  logic [21:0]        s3_m_q;
  logic signed [16:0] s3_asm_q;
  logic [24:0]        dist_num;
  logic [50:0]        dist_prod;

  logic [14:0]        dsm;

  assign pop_o = !qstat_i.empty;

  assign sqx      = head_i.dx * head_i.dx;
  assign sqy      = head_i.dy * head_i.dy;
  assign ang_num  = ANG_BIAS - {1'b0, head_i.adiff, 8'b0};
  assign ang_prod = 49'(ang_num) * 49'(ANG_RECIP);

  always_ff @(posedge clk_i) begin
    s1_sqx_q <= sqx[31:0];
    s1_sqy_q <= sqy[31:0];
    s1_aq_q  <= ang_prod[ANG_SHIFT +: 17];
  end

  assign sum_sq = {1'b0, s1_sqx_q} + {1'b0, s1_sqy_q};

  always_ff @(posedge clk_i) begin
    s2_rad_q <= RAD_W'({sum_sq, 14'b0});
    s2_asm_q <= signed'(s1_aq_q - ANG_OFFSET);
  end

  pfm_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_vld_q),
    .rad_i    (s2_rad_q),
    .side_i   (s2_asm_q),
    .valid_o  (sq_vld),
    .root_o   (sq_root),
    .rem_nz_o (sq_rem_nz),
    .side_o   (sq_asm)
  );

  // ceiling root plus rounding offset, then reciprocal multiply
  assign dist_num  = 25'(sq_root) + 25'(sq_rem_nz) + DIST_RND;
  assign dist_prod = 51'(dist_num) * 51'(DIST_RECIP);

  always_ff @(posedge clk_i) begin
    s3_m_q   <= dist_prod[DIST_SHIFT +: 22];
    s3_asm_q <= sq_asm;
  end

  assign dsm = (s3_m_q >= MEMB_HALF) ? '0 : 15'(MEMB_HALF - s3_m_q);

  always_ff @(posedge clk_i) begin
    dist_small_o  <= dsm;
    dist_large_o  <= 16'(MEMB_ONE) - 16'(dsm);
    angle_small_o <= s3_asm_q;
    angle_large_o <= MEMB_ONE - 17'(s3_asm_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      s1_vld_q <= pop_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= sq_vld;
      valid_o  <= s3_vld_q;
    end
  end

endmodule

// ----- design/pose_fuzzy_membership.sv -----
// path: each item goes through the queue, then the squares, radicand, root, divide and output registers
// throughput: one item per cycle while busy is low, set by the 24-stage root pipeline and the queue drain
// results cannot be held off, so the queue never fills and busy stays low in use
// reset: async active low, clears the queue and all valid bits, no clearing pass
module pose_fuzzy_membership
  import pfm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] robot_x_i,
  input  logic signed [15:0] robot_y_i,
  input  logic signed [14:0] robot_heading_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic signed [14:0] target_heading_i,
  output logic               valid_o,
  output logic [14:0]        dist_small_o,
  output logic [15:0]        dist_large_o,
  output logic signed [16:0] angle_small_o,
  output logic [16:0]        angle_large_o
);

  pfm_qstat_t qstat;
  pfm_entry_t entry;
  pfm_entry_t head;
  logic       push;
  logic       pop;

  assign busy = qstat.full;

  pfm_front u_front (
    .start_i          (start),
    .robot_x_i        (robot_x_i),
    .robot_y_i        (robot_y_i),
    .robot_heading_i  (robot_heading_i),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .target_heading_i (target_heading_i),
    .qstat_i          (qstat),
    .push_o           (push),
    .entry_o          (entry)
  );

  pfm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  pfm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .valid_o       (valid_o),
    .dist_small_o  (dist_small_o),
    .dist_large_o  (dist_large_o),
    .angle_small_o (angle_small_o),
    .angle_large_o (angle_large_o)
  );

endmodule

// ----- design/pfm_chk.sv -----
`include "pose_fuzzy_membership_defines.svh"

module pfm_chk
  import pfm_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               valid_o,
  input logic [14:0]        dist_small_o,
  input logic [15:0]        dist_large_o,
  input logic signed [16:0] angle_small_o,
  input logic [16:0]        angle_large_o
);

  logic [16:0] dist_sum;
  logic [16:0] angle_sum;

  assign dist_sum  = 17'(dist_small_o) + 17'(dist_large_o);
  assign angle_sum = 17'(angle_small_o) + angle_large_o;

  `PFM_ASSERT_IMPL(a_never_busy, 1'b1, !busy, "queue filled although results drain every cycle")
  `PFM_ASSERT_DLY(a_latency, start && !busy, PIPE_LAT, valid_o, "result not strobed on time")
  `PFM_ASSERT_IMPL(a_dist_range, valid_o, dist_small_o <= 15'd16384, "dist_small above one half")
  `PFM_ASSERT_IMPL(a_dist_sum, valid_o, dist_sum == MEMB_ONE, "distance memberships inconsistent")
  `PFM_ASSERT_IMPL(a_angle_sum, valid_o, angle_sum == MEMB_ONE, "angle memberships inconsistent")

endmodule

bind pose_fuzzy_membership pfm_chk u_pfm_chk (.*);
